### rtl/core/zrbe_pkg.sv
// shared constants, codes and controller/datapath bundles for the zero-run byte encoder
// no dependencies
`default_nettype none

package zrbe_pkg;

    localparam int MAX_COUNT_GROUPS = 4;
    localparam int GROUP_BITS       = 7;
    localparam int COUNT_W          = 28;
    localparam int RUN_BITS         = (GROUP_BITS * MAX_COUNT_GROUPS > COUNT_W) ?
                                      COUNT_W : GROUP_BITS * MAX_COUNT_GROUPS;
    localparam int GRP_W            = (MAX_COUNT_GROUPS > 1) ? $clog2(MAX_COUNT_GROUPS) : 1;

    localparam logic [COUNT_W-1:0] RUN_LIMIT = COUNT_W'((64'd1 << RUN_BITS) - 64'd1);

    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [7:0] RUN_MARKER = 8'h00;
    localparam logic [7:0] GROUP_MASK = 8'h7f;
    localparam logic [7:0] GROUP_CONT = 8'h80;

    typedef struct packed {
        logic load_byte;
        logic add_one;
        logic add_count;
        logic take_run;
        logic put_marker;
        logic put_group;
        logic put_byte;
        logic group_last;
    } zrbe_cmd_t;

    typedef struct packed {
        logic run_zero;
        logic group_final;
        logic out_free;
    } zrbe_stat_t;

endpackage

`default_nettype wire

### rtl/core/zrbe_if.sv
// valid/ready channel interfaces for the raw input and the coded output
// depends on zrbe_pkg
`default_nettype none

interface zrbe_raw_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    operation;
    logic [7:0]                    data_byte;
    logic [zrbe_pkg::COUNT_W-1:0]  zero_count;

    modport source (output valid, output operation, output data_byte, output zero_count,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input zero_count,
                    output ready);
endinterface

interface zrbe_coded_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/zrbe_ctrl.sv
// sequencing state machine: accepts items and steps through marker, groups and byte
// depends on zrbe_pkg
`default_nettype none

module zrbe_ctrl (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        raw_valid,
    input  wire  [1:0]                 raw_op,
    input  wire                        byte_zero,
    output logic                       raw_ready,
    input  wire  zrbe_pkg::zrbe_stat_t stat,
    output zrbe_pkg::zrbe_cmd_t        cmd
);
    import zrbe_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MARK  = 2'd1;
    localparam logic [1:0] ST_GROUP = 2'd2;
    localparam logic [1:0] ST_BYTE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       byte_pend_reg;
    logic       byte_pend_next;

    assign raw_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        byte_pend_next = byte_pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (raw_valid)
                begin
                    case (raw_op)
                        OP_DATA:
                        begin
                            if (byte_zero)
                            begin
                                cmd.add_one = 1'b1;
                            end
                            else
                            begin
                                cmd.load_byte = 1'b1;
                                if (stat.run_zero)
                                begin
                                    state_next = ST_BYTE;
                                end
                                else
                                begin
                                    cmd.take_run   = 1'b1;
                                    byte_pend_next = 1'b1;
                                    state_next     = ST_MARK;
                                end
                            end
                        end
                        OP_FLUSH:
                        begin
                            if (!stat.run_zero)
                            begin
                                cmd.take_run   = 1'b1;
                                byte_pend_next = 1'b0;
                                state_next     = ST_MARK;
                            end
                        end
                        OP_ADD:
                        begin
                            cmd.add_count = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.put_marker = 1'b1;
                    state_next     = ST_GROUP;
                end
            end
            ST_GROUP:
            begin
                if (stat.out_free)
                begin
                    cmd.put_group  = 1'b1;
                    cmd.group_last = stat.group_final && !byte_pend_reg;
                    if (stat.group_final)
                    begin
                        state_next = byte_pend_reg ? ST_BYTE : ST_IDLE;
                    end
                end
            end
            ST_BYTE:
            begin
                if (stat.out_free)
                begin
                    cmd.put_byte = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_pend_reg <= byte_pend_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/zrbe_dp.sv
// datapath: saturating run counter, group shifter, held byte and output register
// depends on zrbe_pkg
`default_nettype none

module zrbe_dp (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  [7:0]                    data_byte,
    input  wire  [zrbe_pkg::COUNT_W-1:0]  zero_count,
    input  wire  zrbe_pkg::zrbe_cmd_t     cmd,
    output zrbe_pkg::zrbe_stat_t          stat,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [7:0]                    out_byte,
    output logic                          out_last
);
    import zrbe_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] shift_reg;
    logic [COUNT_W-1:0] shift_next;
    logic [GRP_W-1:0]   grp_reg;
    logic [GRP_W-1:0]   grp_next;
    logic [7:0]         byte_reg;
    logic [7:0]         byte_next;
    logic               ovalid_reg;
    logic               ovalid_next;
    logic [7:0]         obyte_reg;
    logic [7:0]         obyte_next;
    logic               olast_reg;
    logic               olast_next;

    logic [COUNT_W-1:0] addend;
    logic [COUNT_W:0]   sum;
    logic               rest_zero;
    logic               put_any;

    assign addend    = cmd.add_one ? COUNT_W'(1) : zero_count;
    assign sum       = {1'b0, count_reg} + {1'b0, addend};
    assign rest_zero = (shift_reg[COUNT_W-1:GROUP_BITS] == '0);
    assign put_any   = cmd.put_marker || cmd.put_group || cmd.put_byte;

    assign stat.run_zero    = (count_reg == '0);
    assign stat.group_final = rest_zero || (grp_reg == GRP_W'(MAX_COUNT_GROUPS - 1));
    assign stat.out_free    = !ovalid_reg || out_ready;

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

    always_comb
    begin
        count_next  = count_reg;
        shift_next  = shift_reg;
        grp_next    = grp_reg;
        byte_next   = byte_reg;
        ovalid_next = ovalid_reg && !out_ready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;

        if (cmd.add_one || cmd.add_count)
        begin
            count_next = (sum > {1'b0, RUN_LIMIT}) ? RUN_LIMIT : sum[COUNT_W-1:0];
        end
        if (cmd.take_run)
        begin
            shift_next = count_reg;
            count_next = '0;
            grp_next   = '0;
        end
        if (cmd.load_byte)
        begin
            byte_next = data_byte;
        end

        // output register load
        if (put_any)
        begin
            ovalid_next = 1'b1;
        end
        if (cmd.put_marker)
        begin
            obyte_next = RUN_MARKER;
            olast_next = 1'b0;
        end
        if (cmd.put_group)
        begin
            obyte_next = (shift_reg[7:0] & GROUP_MASK) |
                         (stat.group_final ? 8'h00 : GROUP_CONT);
            olast_next = cmd.group_last;
            shift_next = shift_reg >> GROUP_BITS;
            grp_next   = grp_reg + GRP_W'(1);
        end
        if (cmd.put_byte)
        begin
            obyte_next = byte_reg;
            olast_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            grp_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            grp_reg    <= grp_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        byte_reg  <= byte_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

endmodule

`default_nettype wire

### rtl/core/zero_run_byte_encoder_top.sv
// Zero-run byte encoder. Zero data bytes and add-zeros operations only grow a pending run
// count (saturating at 2^28-1); a nonzero byte or a flush sends the run as a 0x00 marker and
// one to four 7-bit groups, low group first, with bit 7 set on all but the last group, and a
// nonzero byte then follows as itself. An item that only counts, and an undefined operation,
// leaves the block ready for the next item. An item that sends bytes holds off new input until
// its last byte is loaded into the single output register, which moves one byte per transfer;
// output stalls hold the sequence in its current step.
// depends on zrbe_pkg, zrbe_if, zrbe_ctrl, zrbe_dp
`default_nettype none

module zero_run_byte_encoder_top (
    input  wire           clk,
    input  wire           rst_n,
    zrbe_raw_if.sink      raw,
    zrbe_coded_if.source  coded
);
    import zrbe_pkg::*;

    zrbe_cmd_t  cmd;
    zrbe_stat_t stat;
    logic       byte_zero;

    assign byte_zero = (raw.data_byte == 8'h00);

    zrbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw.valid),
        .raw_op    (raw.operation),
        .byte_zero (byte_zero),
        .raw_ready (raw.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    zrbe_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (raw.data_byte),
        .zero_count (raw.zero_count),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (coded.valid),
        .out_ready  (coded.ready),
        .out_byte   (coded.out_byte),
        .out_last   (coded.last)
    );

endmodule

`default_nettype wire

### rtl/core/zrbe_chk.sv
// port-level checks for the zero-run byte encoder, bound to the top level
// depends on zrbe_pkg and zero_run_byte_encoder_top
`default_nettype none

module zrbe_chk (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        raw_valid,
    input  wire        raw_ready,
    input  wire  [1:0] raw_op,
    input  wire  [7:0] raw_byte,
    input  wire        out_valid,
    input  wire        out_ready,
    input  wire  [7:0] out_byte,
    input  wire        out_last
);
    import zrbe_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("stalled output changed");

    // a nonzero byte always leaves work behind
    a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
        raw_valid && raw_ready && raw_op == OP_DATA && raw_byte != 8'h00 |=> !raw_ready)
        else $error("input taken while nonzero byte pending");

    // counting-only items keep the block free
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        raw_valid && raw_ready && (raw_op == OP_ADD || raw_op == OP_RSVD ||
        (raw_op == OP_DATA && raw_byte == 8'h00)) |=> raw_ready)
        else $error("counting item left block busy");

    // mid-sequence transfer is followed directly by the next byte
    a_mid_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("gap in the middle of a run code");

endmodule

bind zero_run_byte_encoder_top zrbe_chk u_zrbe_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .raw_valid (raw.valid),
    .raw_ready (raw.ready),
    .raw_op    (raw.operation),
    .raw_byte  (raw.data_byte),
    .out_valid (coded.valid),
    .out_ready (coded.ready),
    .out_byte  (coded.out_byte),
    .out_last  (coded.last)
);

`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for the zero-run byte encoder: queue-fed driver, clocked monitor
// and an in-bench encoder model that predicts every coded byte from each accepted transfer
// depends on zrbe_pkg, zrbe_if and zero_run_byte_encoder_top
`timescale 1ns / 1ps

module testbench;

    import zrbe_pkg::*;

    typedef struct {
        logic [1:0]         op;
        logic [7:0]         data;
        logic [COUNT_W-1:0] count;
        bit                 drain;
    } raw_item_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
    } coded_byte_t;

    logic clk;
    logic rst_n;

    zrbe_raw_if   raw_ch ();
    zrbe_coded_if coded_ch ();

    zero_run_byte_encoder_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_ch),
        .coded (coded_ch)
    );

    raw_item_t          raw_pending_q[$];
    coded_byte_t        coded_bytes_q[$];
    logic [COUNT_W-1:0] zero_run;
    logic [7:0]         run_buf[0:7];
    int                 run_n;
    int                 fail_count;
    int                 items_sent;
    int                 bytes_seen;
    int                 gap_left;
    int                 stall_left;
    int                 hold_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic add_to_run(input logic [COUNT_W-1:0] n);
        logic [COUNT_W:0] sum;
        sum = {1'b0, zero_run} + {1'b0, n};
        if (sum > {1'b0, RUN_LIMIT})
            zero_run = RUN_LIMIT;
        else
            zero_run = sum[COUNT_W-1:0];
    endtask

    task automatic code_run();
        logic [COUNT_W-1:0] c;
        int                 g;
        c = zero_run;
        g = 0;
        if (c != '0)
        begin
            run_buf[run_n] = RUN_MARKER;
            run_n++;
            while (c != '0 && g < MAX_COUNT_GROUPS)
            begin
                if (g > 0)
                    run_buf[run_n-1] = run_buf[run_n-1] | GROUP_CONT;
                run_buf[run_n] = 8'(c) & GROUP_MASK;
                run_n++;
                c = c >> GROUP_BITS;
                g++;
            end
            zero_run = '0;
        end
    endtask

    task automatic encode_item(input raw_item_t it);
        coded_byte_t b;
        run_n = 0;
        case (it.op)
            OP_DATA:
            begin
                if (it.data == 8'd0)
                    add_to_run(COUNT_W'(1));
                else
                begin
                    code_run();
                    run_buf[run_n] = it.data;
                    run_n++;
                end
            end
            OP_FLUSH: code_run();
            OP_ADD:   add_to_run(it.count);
            default:  ;
        endcase
        for (int i = 0; i < run_n; i++)
        begin
            b.out_byte = run_buf[i];
            b.last     = (i == run_n - 1);
            coded_bytes_q.push_back(b);
        end
    endtask

    task automatic push_item(input logic [1:0] op, input logic [7:0] data,
                             input logic [COUNT_W-1:0] count, input bit drain);
        raw_item_t it;
        it.op    = op;
        it.data  = data;
        it.count = count;
        it.drain = drain;
        raw_pending_q.push_back(it);
    endtask

    function automatic int draw_wait(input int idx);
        if (idx >= 120 && idx < 220)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [COUNT_W-1:0] draw_count();
        case ($urandom_range(0, 5))
            0:       return COUNT_W'($urandom_range(0, 3));
            1:       return RUN_LIMIT;
            2:       return COUNT_W'($urandom);
            3:       return COUNT_W'(1) << $urandom_range(0, COUNT_W - 1);
            default: return COUNT_W'($urandom_range(1, 300));
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        logic fire;
        logic next_valid;
        if (rst_n)
        begin
            fire = raw_ch.valid && raw_ch.ready;
            if (fire)
            begin
                encode_item(raw_pending_q.pop_front());
                items_sent++;
                gap_left = draw_wait(items_sent);
            end
            if (fire || !raw_ch.valid)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (raw_pending_q.size() > 0 &&
                         (!raw_pending_q[0].drain || coded_bytes_q.size() == 0))
                begin
                    next_valid           = 1'b1;
                    raw_ch.operation  <= raw_pending_q[0].op;
                    raw_ch.data_byte  <= raw_pending_q[0].data;
                    raw_ch.zero_count <= raw_pending_q[0].count;
                end
                raw_ch.valid <= next_valid;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        coded_byte_t exp_b;
        logic        next_ready;
        if (rst_n)
        begin
            if (coded_ch.valid && coded_ch.ready)
            begin
                if (coded_bytes_q.size() == 0)
                begin
                    $error("unexpected transfer: out_byte %0h last %0b",
                           coded_ch.out_byte, coded_ch.last);
                    fail_count++;
                end
                else
                begin
                    exp_b = coded_bytes_q.pop_front();
                    if (coded_ch.out_byte !== exp_b.out_byte)
                    begin
                        $error("out_byte: expected %0h, got %0h", exp_b.out_byte,
                               coded_ch.out_byte);
                        fail_count++;
                    end
                    if (coded_ch.last !== exp_b.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_b.last, coded_ch.last);
                        fail_count++;
                    end
                end
                bytes_seen++;
                stall_left = draw_wait(bytes_seen + 200);
                // long back-pressure so the input side fills up and stalls
                if (bytes_seen == 60)
                    hold_left = 500;
            end
            next_ready = 1'b0;
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else
                next_ready = 1'b1;
            coded_ch.ready <= next_ready;
        end
    end

    initial
    begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int counted;
        int pick;
        int settle;
        clk                = 1'b0;
        rst_n              = 1'b0;
        raw_ch.valid       = 1'b0;
        raw_ch.operation   = OP_DATA;
        raw_ch.data_byte   = 8'd0;
        raw_ch.zero_count  = '0;
        coded_ch.ready     = 1'b0;
        zero_run           = '0;
        fail_count         = 0;
        items_sent         = 0;
        bytes_seen         = 0;
        gap_left           = 0;
        stall_left         = 0;
        hold_left          = 0;

        // directed part
        push_item(OP_DATA, 8'h01, COUNT_W'($urandom), 0);
        push_item(OP_DATA, 8'hff, COUNT_W'($urandom), 0);
        push_item(OP_DATA, 8'h80, COUNT_W'($urandom), 0);
        push_item(OP_DATA, 8'h7f, RUN_LIMIT, 0);
        push_item(OP_DATA, 8'h00, '0, 0);
        push_item(OP_DATA, 8'h55, COUNT_W'($urandom), 0);
        push_item(OP_FLUSH, 8'hff, RUN_LIMIT, 0);
        push_item(OP_ADD, 8'hff, COUNT_W'(127), 0);
        push_item(OP_FLUSH, 8'h00, '0, 0);
        push_item(OP_ADD, 8'h00, COUNT_W'(128), 0);
        push_item(OP_FLUSH, 8'h5a, COUNT_W'($urandom), 0);
        push_item(OP_ADD, 8'h3c, RUN_LIMIT, 0);
        push_item(OP_FLUSH, 8'h00, '0, 0);
        push_item(OP_ADD, 8'h00, RUN_LIMIT, 0);
        push_item(OP_ADD, 8'hff, RUN_LIMIT, 0);
        push_item(OP_DATA, 8'h01, RUN_LIMIT, 0);
        push_item(OP_RSVD, 8'hff, RUN_LIMIT, 0);
        push_item(OP_RSVD, 8'h00, '0, 0);
        push_item(OP_ADD, 8'h11, '0, 0);
        push_item(OP_FLUSH, 8'h22, '0, 0);
        push_item(OP_ADD, 8'h00, COUNT_W'(16383), 0);
        push_item(OP_DATA, 8'haa, COUNT_W'(0), 0);
        push_item(OP_ADD, 8'h00, COUNT_W'(2097152), 0);
        push_item(OP_DATA, 8'h00, RUN_LIMIT, 0);
        push_item(OP_FLUSH, 8'h00, '0, 0);

        // random part
        counted = 0;
        while (counted < 500)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                push_item(OP_DATA, 8'($urandom_range(1, 255)), COUNT_W'($urandom),
                          counted == 250);
            else if (pick < 65)
                push_item(OP_DATA, 8'h00, COUNT_W'($urandom), counted == 250);
            else if (pick < 83)
                push_item(OP_ADD, 8'($urandom), draw_count(), counted == 250);
            else if (pick < 97)
                push_item(OP_FLUSH, 8'($urandom), COUNT_W'($urandom), counted == 250);
            else
                push_item(OP_RSVD, 8'($urandom), COUNT_W'($urandom), 0);
            if (pick < 97)
                counted++;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (raw_pending_q.size() > 0)
            @(posedge clk);
        settle = 0;
        while (coded_bytes_q.size() > 0 && settle < 20000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (20) @(posedge clk);
        if (coded_bytes_q.size() > 0)
        begin
            $error("%0d expected transfers never arrived", coded_bytes_q.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
